FILE: sv/lppr_pkg.sv
// Package with the shared types and constants of the length-prefixed packet ring.
`timescale 1ns / 1ps

package lppr_pkg;

  localparam int HDR_BYTES = 4;
  localparam int LEN_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 32;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_HDR  = 2'd0,
    OP_PUSH_DATA = 2'd1,
    OP_POP_BEGIN = 2'd2,
    OP_POP_NEXT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DROP    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BAD_LEN = 3'd3,
    ST_SEQ     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HDR_HI,
    BK_LEN_LO,
    BK_LEN_HI,
    BK_BYTE
  } bstate_t;

  typedef struct packed {
    op_t                op;
    logic               len_zero;
    logic               limit_zero;
    logic [LEN_W-1:0]   plen;
    logic [BYTE_W-1:0]  din;
    logic [LEN_W-1:0]   limit;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  data_out;
    logic [LEN_W-1:0]   read_length;
    logic               last_byte;
    logic [CNT_W-1:0]   packets_queued;
    logic [CNT_W-1:0]   bytes_queued;
    logic [CNT_W-1:0]   packets_dropped;
  } res_t;

endpackage

FILE: sv/lppr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module lppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lppr_front.sv
// Front end: accepts input beats, decodes them into commands and queues them.
`timescale 1ns / 1ps

module lppr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [15:0]         packet_length,
  input  logic [7:0]          data_in,
  input  logic [15:0]         read_limit,
  output logic                q_valid,
  output lppr_pkg::cmd_t      q_cmd,
  input  logic                q_pop
);

  lppr_pkg::cmd_t                    entry_r [lppr_pkg::QDEPTH];
  logic [lppr_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [lppr_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [lppr_pkg::QCNT_W-1:0]       count_r, count_nxt;
  lppr_pkg::cmd_t                    cmd_in;
  logic                              push;

  always_comb begin
    cmd_in            = '0;
    cmd_in.plen       = packet_length;
    cmd_in.din        = data_in;
    cmd_in.limit      = read_limit;
    cmd_in.len_zero   = (packet_length == '0);
    cmd_in.limit_zero = (read_limit == '0);
    unique case (action)
      2'd0:    cmd_in.op = lppr_pkg::OP_PUSH_HDR;
      2'd1:    cmd_in.op = lppr_pkg::OP_PUSH_DATA;
      2'd2:    cmd_in.op = lppr_pkg::OP_POP_BEGIN;
      default: cmd_in.op = lppr_pkg::OP_POP_NEXT;
    endcase
  end

  assign in_ready = (count_r != lppr_pkg::QCNT_W'(lppr_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

FILE: sv/lppr_back.sv
// Back end: executes queued commands against the byte ring and registers each result.
`timescale 1ns / 1ps

module lppr_back #(
  parameter int RING_BYTES = 65536,
  localparam int AW        = $clog2(RING_BYTES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lppr_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lppr_pkg::res_t      res
);

  localparam int          CW   = (AW > 17) ? AW : 17;
  localparam logic [AW:0] RING = (AW + 1)'(RING_BYTES);
  localparam logic [AW:0] HDR  = (AW + 1)'(lppr_pkg::HDR_BYTES);

  lppr_pkg::bstate_t  state_r, state_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [AW-1:0]      rp_r, rp_nxt;
  logic [AW-1:0]      rd_r, rd_nxt;
  logic [AW-1:0]      pend_r, pend_nxt;
  logic [AW-1:0]      wa_r, wa_nxt;
  logic [15:0]        wleft_r, wleft_nxt;
  logic               wacc_r, wacc_nxt;
  logic [15:0]        rleft_r, rleft_nxt;
  logic [31:0]        pk_r, pk_nxt;
  logic [31:0]        by_r, by_nxt;
  logic [31:0]        dr_r, dr_nxt;
  lppr_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [7:0]         len_lo_r, len_lo_nxt;
  logic               out_valid_r, out_valid_nxt;
  lppr_pkg::status_t  o_status_r, o_status_nxt;
  logic [7:0]         o_data_r, o_data_nxt;
  logic [15:0]        o_rlen_r, o_rlen_nxt;
  logic               o_last_r, o_last_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  logic               take, out_free, res_valid;
  logic [AW:0]        diff;
  logic [AW-1:0]      used, avail;
  logic               drop, empty, hdr_ok, pop_ok, next_ok;
  logic [15:0]        len;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [AW:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= RING) begin
      sum = sum - RING;
    end
    return sum[AW-1:0];
  endfunction

  lppr_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    diff = {1'b0, wp_r} - {1'b0, rp_r};
    if (wp_r < rp_r) begin
      diff = diff + RING;
    end
    used  = diff[AW-1:0];
    avail = AW'(RING - (AW + 1)'(1) - {1'b0, used});
  end

  assign drop     = CW'(avail) < CW'({1'b0, q_cmd.plen} + 17'(lppr_pkg::HDR_BYTES));
  assign empty    = {1'b0, used} < HDR;
  assign hdr_ok   = (wleft_r == '0) && !q_cmd.len_zero && !drop;
  assign pop_ok   = (rleft_r == '0) && !q_cmd.limit_zero && !empty;
  assign next_ok  = (rleft_r != '0);
  assign out_free = !out_valid_r || out_ready;
  assign take     = (state_r == lppr_pkg::BK_IDLE) && q_valid && out_free;
  assign len      = {ram_rdata, len_lo_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lppr_pkg::BK_IDLE: begin
        if (take) begin
          unique case (q_cmd.op)
            lppr_pkg::OP_PUSH_HDR:  if (hdr_ok)  state_nxt = lppr_pkg::BK_HDR_HI;
            lppr_pkg::OP_PUSH_DATA: state_nxt = lppr_pkg::BK_IDLE;
            lppr_pkg::OP_POP_BEGIN: if (pop_ok)  state_nxt = lppr_pkg::BK_LEN_LO;
            lppr_pkg::OP_POP_NEXT:  if (next_ok) state_nxt = lppr_pkg::BK_BYTE;
          endcase
        end
      end
      lppr_pkg::BK_HDR_HI: state_nxt = lppr_pkg::BK_IDLE;
      lppr_pkg::BK_LEN_LO: state_nxt = lppr_pkg::BK_LEN_HI;
      lppr_pkg::BK_LEN_HI: state_nxt = lppr_pkg::BK_IDLE;
      lppr_pkg::BK_BYTE:   state_nxt = lppr_pkg::BK_IDLE;
      default:             state_nxt = lppr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    rd_nxt       = rd_r;
    pend_nxt     = pend_r;
    wa_nxt       = wa_r;
    wleft_nxt    = wleft_r;
    wacc_nxt     = wacc_r;
    rleft_nxt    = rleft_r;
    pk_nxt       = pk_r;
    by_nxt       = by_r;
    dr_nxt       = dr_r;
    cmd_nxt      = cmd_r;
    len_lo_nxt   = len_lo_r;
    ram_we       = 1'b0;
    ram_waddr    = wp_r;
    ram_wdata    = q_cmd.plen[7:0];
    ram_raddr    = rd_r;
    q_pop        = 1'b0;
    res_valid    = 1'b0;
    o_status_nxt = o_status_r;
    o_data_nxt   = o_data_r;
    o_rlen_nxt   = o_rlen_r;
    o_last_nxt   = o_last_r;

    unique case (state_r)
      lppr_pkg::BK_IDLE: begin
        if (q_cmd.op == lppr_pkg::OP_POP_BEGIN) begin
          ram_raddr = rp_r;
        end
        if (take) begin
          q_pop        = 1'b1;
          cmd_nxt      = q_cmd;
          o_status_nxt = lppr_pkg::ST_OK;
          o_data_nxt   = '0;
          o_rlen_nxt   = '0;
          o_last_nxt   = 1'b0;
          unique case (q_cmd.op)
            lppr_pkg::OP_PUSH_HDR: begin
              res_valid = !hdr_ok;
              if (wleft_r != '0) begin
                o_status_nxt = lppr_pkg::ST_SEQ;
              end else if (q_cmd.len_zero) begin
                o_status_nxt = lppr_pkg::ST_BAD_LEN;
              end else begin
                wleft_nxt = q_cmd.plen;
                if (drop) begin
                  wacc_nxt     = 1'b0;
                  dr_nxt       = dr_r + 32'd1;
                  o_status_nxt = lppr_pkg::ST_DROP;
                end else begin
                  ram_we   = 1'b1;
                  wacc_nxt = 1'b1;
                  pk_nxt   = pk_r + 32'd1;
                  by_nxt   = by_r + 32'(q_cmd.plen);
                  wa_nxt   = ring_add(wp_r, HDR);
                end
              end
            end
            lppr_pkg::OP_PUSH_DATA: begin
              res_valid = 1'b1;
              if (wleft_r == '0) begin
                o_status_nxt = lppr_pkg::ST_SEQ;
              end else if (!wacc_r) begin
                wleft_nxt    = wleft_r - 16'd1;
                o_status_nxt = lppr_pkg::ST_DROP;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wa_r;
                ram_wdata = q_cmd.din;
                wa_nxt    = ring_add(wa_r, (AW + 1)'(1));
                wleft_nxt = wleft_r - 16'd1;
                if (wleft_r == 16'd1) begin
                  wp_nxt   = ring_add(wa_r, (AW + 1)'(1));
                  wacc_nxt = 1'b0;
                end
              end
            end
            lppr_pkg::OP_POP_BEGIN: begin
              res_valid = !pop_ok;
              if (rleft_r != '0) begin
                o_status_nxt = lppr_pkg::ST_SEQ;
              end else if (q_cmd.limit_zero) begin
                o_status_nxt = lppr_pkg::ST_BAD_LEN;
              end else if (empty) begin
                o_status_nxt = lppr_pkg::ST_EMPTY;
              end
            end
            lppr_pkg::OP_POP_NEXT: begin
              res_valid = !next_ok;
              if (!next_ok) begin
                o_status_nxt = lppr_pkg::ST_SEQ;
              end
            end
          endcase
        end
      end
      lppr_pkg::BK_HDR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = ring_add(wp_r, (AW + 1)'(1));
        ram_wdata = cmd_r.plen[15:8];
        res_valid = 1'b1;
      end
      lppr_pkg::BK_LEN_LO: begin
        len_lo_nxt = ram_rdata;
        ram_raddr  = ring_add(rp_r, (AW + 1)'(1));
      end
      lppr_pkg::BK_LEN_HI: begin
        pend_nxt   = ring_add(rp_r, (AW + 1)'({1'b0, len} + 17'(lppr_pkg::HDR_BYTES)));
        rd_nxt     = ring_add(rp_r, HDR);
        o_rlen_nxt = (len < cmd_r.limit) ? len : cmd_r.limit;
        rleft_nxt  = o_rlen_nxt;
        res_valid  = 1'b1;
      end
      lppr_pkg::BK_BYTE: begin
        o_data_nxt = ram_rdata;
        rd_nxt     = ring_add(rd_r, (AW + 1)'(1));
        rleft_nxt  = rleft_r - 16'd1;
        if (rleft_r == 16'd1) begin
          o_last_nxt = 1'b1;
          rp_nxt     = pend_r;
        end
        res_valid  = 1'b1;
      end
      default: begin
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lppr_pkg::BK_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      rd_r        <= '0;
      pend_r      <= '0;
      wa_r        <= '0;
      wleft_r     <= '0;
      wacc_r      <= 1'b0;
      rleft_r     <= '0;
      pk_r        <= '0;
      by_r        <= '0;
      dr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      rd_r        <= rd_nxt;
      pend_r      <= pend_nxt;
      wa_r        <= wa_nxt;
      wleft_r     <= wleft_nxt;
      wacc_r      <= wacc_nxt;
      rleft_r     <= rleft_nxt;
      pk_r        <= pk_nxt;
      by_r        <= by_nxt;
      dr_r        <= dr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    len_lo_r   <= len_lo_nxt;
    o_status_r <= o_status_nxt;
    o_data_r   <= o_data_nxt;
    o_rlen_r   <= o_rlen_nxt;
    o_last_r   <= o_last_nxt;
  end

  // No command starts until the pending result is taken, so the live counters
  // still match the beat that is on the output.
  assign out_valid           = out_valid_r;
  assign res.status          = o_status_r;
  assign res.data_out        = o_data_r;
  assign res.read_length     = o_rlen_r;
  assign res.last_byte       = o_last_r;
  assign res.packets_queued  = pk_r;
  assign res.bytes_queued    = by_r;
  assign res.packets_dropped = dr_r;

endmodule

FILE: sv/length_prefixed_packet_ring.sv
// Top level of the length-prefixed packet ring.
`timescale 1ns / 1ps

// Every input beat carries one command in in_tuser: push header, push data byte,
// pop begin or pop next byte. Every command returns exactly one result beat with
// a status in out_tuser, the delivered byte or the announced read length and the
// three running counters in out_tdata, and out_tlast on the final byte that a read delivers.
// Packets are stored in a byte RAM of RING_BYTES entries as a length header
// followed by the data; a packet becomes readable once its last byte is written.
// A two-entry command queue separates the input from the execution engine, so
// the input keeps accepting while a result waits on out_tready.
// The engine finishes each command before it takes the next: an accepted header
// needs two byte writes on the single RAM write port, and a pop begin and a pop
// next byte read through the registered RAM read port.
// Reset clears the pointers, counters and queue; the RAM needs no clearing.
// While out_tready is low the result holds and the engine waits, and the input
// stalls once the queue is full.
module length_prefixed_packet_ring #(
  parameter int RING_BYTES = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // packet_length[15:0], data_in[23:16], read_limit[39:24]
  input  logic [1:0]   in_tuser,   // action[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // data_out[7:0], read_length[23:8], packets_queued[55:24],
                                   // bytes_queued[87:56], packets_dropped[119:88]
  output logic [2:0]   out_tuser,  // status[2:0]
  output logic         out_tlast
);

  logic            q_valid, q_pop;
  lppr_pkg::cmd_t  q_cmd;
  lppr_pkg::res_t  res;

  lppr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .action        (in_tuser),
    .packet_length (in_tdata[15:0]),
    .data_in       (in_tdata[23:16]),
    .read_limit    (in_tdata[39:24]),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  lppr_back #(.RING_BYTES(RING_BYTES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.packets_dropped, res.bytes_queued, res.packets_queued,
                      res.read_length, res.data_out};
  assign out_tuser = res.status;
  assign out_tlast = res.last_byte;

endmodule

FILE: sv/lppr_checker.sv
// Port-level checks of the result channel of the packet ring, bound to the top level.
`timescale 1ns / 1ps

module lppr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == 3'(lppr_pkg::ST_OK) && out_tdata[23:8] == '0)
    else $error("last byte beat with bad status or read length");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 3'(lppr_pkg::ST_OK) |-> out_tdata[23:0] == '0 && !out_tlast)
    else $error("failed command carries data or length");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind length_prefixed_packet_ring lppr_checker u_lppr_checker (.*);
